/* design/crgu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crgu_pkg
// Shared constants for the Catmull-Rom grid upsampler: widths, defaults and
// configuration register indexes.
// ----------------------------------------------------------------------------
package crgu_pkg;

    localparam int SAMPLE_BITS       = 16;
    localparam int DEF_ANCHOR_DEPTH  = 4096;
    localparam int DEF_FRAC_BITS     = 16;
    // working width of spline values: three folds grow a sample by at most 12x each
    localparam int VAL_W             = 32;
    // linear anchor address before the range check
    localparam int ADDR_W            = 28;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 9;
    localparam int COORD_W           = 8;
    localparam int SIZE_W            = 9;
    localparam int STEP_W            = 7;
    localparam int AADDR_W           = 12;

    localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_DEPTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Z     = 3'd6;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

endpackage

/* design/crgu_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crgu_div
// Restoring divider, one quotient bit per cycle, 7-bit divisor.
// ----------------------------------------------------------------------------
module crgu_div #(
    parameter int DW = 25
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DW-1:0]                i_dividend,
    input  logic [crgu_pkg::STEP_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [DW-1:0]                o_quotient
);
    import crgu_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DW-1:0]     r_num;
    logic [DW-1:0]     r_quo;
    logic [STEP_W-1:0] r_rem;
    logic [STEP_W-1:0] r_div;
    logic [STEP_W:0]   w_t;
    logic              w_ge;
    logic [STEP_W-1:0] w_nrem;

    assign w_t    = {r_rem, r_num[DW-1]};
    assign w_ge   = w_t >= {1'b0, r_div};
    assign w_nrem = w_ge ? STEP_W'(w_t - {1'b0, r_div}) : w_t[STEP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
                r_num  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                r_quo <= {r_quo[DW-2:0], w_ge};
                r_rem <= w_nrem;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* design/crgu_cubic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crgu_cubic
// Shared Catmull-Rom evaluator: one multiplier with rounding, used three
// times per spline under a small sequencer.
// ----------------------------------------------------------------------------
module crgu_cubic #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [crgu_pkg::VAL_W-1:0]  i_p0,
    input  logic signed [crgu_pkg::VAL_W-1:0]  i_p1,
    input  logic signed [crgu_pkg::VAL_W-1:0]  i_p2,
    input  logic signed [crgu_pkg::VAL_W-1:0]  i_p3,
    input  logic [FRAC_BITS-1:0]               i_frac,
    output logic                               o_done,
    output logic signed [crgu_pkg::VAL_W-1:0]  o_result
);
    import crgu_pkg::*;

    localparam int PW = VAL_W + FRAC_BITS + 1;
    localparam logic signed [PW-1:0]    HALF = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [VAL_W-1:0] ONE  = VAL_W'(1);

    typedef enum logic [1:0] {
        CB_IDLE,
        CB_COEF,
        CB_MUL,
        CB_FIN
    } t_cb_state;

    t_cb_state                r_state;
    logic [1:0]               r_k;
    logic                     r_done;
    logic [FRAC_BITS-1:0]     r_f;
    logic signed [VAL_W-1:0]  r_p0, r_p1, r_p2, r_p3;
    logic signed [VAL_W-1:0]  r_a, r_b, r_c, r_h, r_res;
    logic signed [VAL_W-1:0]  w_d, w_op;
    logic signed [PW-1:0]     w_prod, w_rnd, w_sh;

    assign w_d    = r_p1 - r_p2;
    assign w_op   = ((r_k == 2'd0) ? r_c : (r_k == 2'd1) ? r_b : r_a) + r_h;
    assign w_prod = $signed(w_op) * $signed({1'b0, r_f});
    assign w_rnd  = w_prod + HALF;
    assign w_sh   = w_rnd >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CB_IDLE;
            r_done  <= 1'b0;
            r_k     <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                CB_IDLE: begin
                    if (i_start) begin
                        r_p0    <= i_p0;
                        r_p1    <= i_p1;
                        r_p2    <= i_p2;
                        r_p3    <= i_p3;
                        r_f     <= i_frac;
                        r_state <= CB_COEF;
                    end
                end
                CB_COEF: begin
                    r_a <= r_p2 - r_p0;
                    r_b <= (r_p0 <<< 1) - ((r_p1 <<< 2) + r_p1) + (r_p2 <<< 2) - r_p3;
                    r_c <= (w_d <<< 1) + w_d + r_p3 - r_p0;
                    r_h <= '0;
                    r_k <= '0;
                    r_state <= CB_MUL;
                end
                CB_MUL: begin
                    // horner: c, then b, then a
                    r_h <= w_sh[VAL_W-1:0];
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd2) begin
                        r_state <= CB_FIN;
                    end
                end
                CB_FIN: begin
                    r_res   <= r_p1 + ((r_h + ONE) >>> 1);
                    r_done  <= 1'b1;
                    r_state <= CB_IDLE;
                end
                default: r_state <= CB_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

/* design/crgu_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crgu_store
// Anchor sample memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module crgu_store #(
    parameter int DEPTH = 4096
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [$clog2(DEPTH)-1:0]                 i_waddr,
    input  logic signed [crgu_pkg::SAMPLE_BITS-1:0]  i_wdata,
    input  logic                                     i_re,
    input  logic [$clog2(DEPTH)-1:0]                 i_raddr,
    output logic signed [crgu_pkg::SAMPLE_BITS-1:0]  o_rdata
);
    import crgu_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/catmull_rom_grid_upsampler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_grid_upsampler
// Loads a coarse anchor grid and returns Catmull-Rom interpolated fine-grid
// points over one, two or three axes.
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+-----------------------------------
//   in      | i_in_valid  | o_in_ready  | req_type, anchor addr/value, point
//   out     | o_out_valid | i_out_ready | sample_value, saturated, bad_index
//   cfg     | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// a write beat goes straight to the anchor memory. a read runs one divider pass
// per needed division (1, 3 or 5), the setup states SET1 to SET3, a fetch and
// a load per anchor fetched (4, 16 or 64) and one run of the shared evaluator
// per spline (1, 5 or 21); bad coordinates finish at once.
// the input side waits while a read is in flight; a finished result sits in
// the output register so the next beat can be taken while it stalls.
// reset is synchronous; the anchor memory is not cleared.
// ----------------------------------------------------------------------------
module catmull_rom_grid_upsampler #(
    parameter int ANCHOR_DEPTH = crgu_pkg::DEF_ANCHOR_DEPTH,
    parameter int FRAC_BITS    = crgu_pkg::DEF_FRAC_BITS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic                                     i_req_type,
    input  logic [crgu_pkg::AADDR_W-1:0]             i_anchor_addr,
    input  logic signed [crgu_pkg::SAMPLE_BITS-1:0]  i_anchor_value,
    input  logic [crgu_pkg::COORD_W-1:0]             i_point_x,
    input  logic [crgu_pkg::COORD_W-1:0]             i_point_y,
    input  logic [crgu_pkg::COORD_W-1:0]             i_point_z,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic signed [crgu_pkg::SAMPLE_BITS-1:0]  o_sample_value,
    output logic                                     o_saturated,
    output logic                                     o_bad_index,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [crgu_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [crgu_pkg::CFG_DATA_W-1:0]          i_cfg_data
);
    import crgu_pkg::*;

    localparam int IW = $clog2(ANCHOR_DEPTH);
    localparam int DW = SIZE_W + FRAC_BITS;
    localparam logic signed [VAL_W-1:0] SMAX_V = VAL_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [VAL_W-1:0] SMIN_V = -SMAX_V - VAL_W'(1);
    localparam logic [ADDR_W-1:0]       DEPTH_A = ADDR_W'(ANCHOR_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_DWAIT,
        ST_SET1,
        ST_SET2,
        ST_SET3,
        ST_FETCH,
        ST_LOAD,
        ST_CUBIC,
        ST_DONE
    } t_state;

    t_state                     r_state;
    logic [1:0]                 r_dims;
    logic [SIZE_W-1:0]          r_w, r_h, r_d;
    logic [STEP_W-1:0]          r_sx, r_sy, r_sz;
    logic [COORD_W-1:0]         r_px, r_py, r_pz;
    logic [2:0]                 r_didx;
    logic [SIZE_W-1:0]          r_ax0, r_ay0, r_az0, r_nx, r_ny;
    logic [FRAC_BITS-1:0]       r_frac [3];
    logic [16:0]                r_nxny;
    logic [ADDR_W-1:0]          r_ty, r_tz, r_row_i, r_row_j, r_fa;
    logic [1:0]                 r_ii, r_jj, r_kk;
    logic [1:0]                 r_cnt [3];
    logic signed [VAL_W-1:0]    r_ln [3][4];
    logic [1:0]                 r_lvl;
    logic                       r_cb_go;
    logic signed [VAL_W-1:0]    r_res;
    logic                       r_bad;
    logic                       r_ovalid, r_osat, r_obad;
    logic signed [SAMPLE_BITS-1:0] r_oval;

    logic [1:0]                 w_dims;
    logic [1:0]                 w_lo;
    logic                       w_in_acc, w_coord_bad, w_need;
    logic [STEP_W-1:0]          w_sx1, w_sy1, w_sz1, w_dsor;
    logic [SIZE_W-1:0]          w_dval;
    logic                       w_div_start, w_div_done;
    logic [DW-1:0]              w_quo;
    logic [SIZE_W-1:0]          w_q;
    logic [17:0]                w_ty;
    logic [16:0]                w_nxny;
    logic [25:0]                w_tz;
    logic                       w_cz_last, w_cy_last;
    logic                       w_we, w_re;
    logic signed [SAMPLE_BITS-1:0] w_rdata;
    logic                       w_cb_start, w_cb_done;
    logic signed [VAL_W-1:0]    w_cb_res;
    logic                       w_hi, w_lo_sat;
    logic                       w_out_free;

    assign w_dims   = (r_dims == 2'd0) ? 2'd1 : r_dims;
    assign w_lo     = (w_dims == 2'd3) ? 2'd0 : (w_dims == 2'd2) ? 2'd1 : 2'd2;
    assign w_sx1    = (r_sx == '0) ? STEP_W'(1) : r_sx;
    assign w_sy1    = (r_sy == '0) ? STEP_W'(1) : r_sy;
    assign w_sz1    = (r_sz == '0) ? STEP_W'(1) : r_sz;
    assign w_in_acc = i_in_valid && o_in_ready;

    assign w_coord_bad = ({1'b0, i_point_x} >= r_w)
                      || (w_dims >= 2'd2 && {1'b0, i_point_y} >= r_h)
                      || (w_dims == 2'd3 && {1'b0, i_point_z} >= r_d);

    // division list: px, py, pz, width, height
    always_comb begin
        w_dsor = w_sx1;
        w_dval = {1'b0, r_px};
        w_need = 1'b1;
        case (r_didx)
            3'd0: begin
                w_dsor = w_sx1; w_dval = {1'b0, r_px}; w_need = 1'b1;
            end
            3'd1: begin
                w_dsor = w_sy1; w_dval = {1'b0, r_py}; w_need = (w_dims >= 2'd2);
            end
            3'd2: begin
                w_dsor = w_sz1; w_dval = {1'b0, r_pz}; w_need = (w_dims == 2'd3);
            end
            3'd3: begin
                w_dsor = w_sx1; w_dval = r_w; w_need = (w_dims >= 2'd2);
            end
            3'd4: begin
                w_dsor = w_sy1; w_dval = r_h; w_need = (w_dims == 2'd3);
            end
            default: begin
                w_dsor = w_sx1; w_dval = r_w; w_need = 1'b0;
            end
        endcase
    end

    assign w_div_start = (r_state == ST_DIV) && w_need;
    assign w_q         = w_quo[DW-1:FRAC_BITS];

    assign w_ty   = 18'(r_nx) * 18'(r_ay0);
    assign w_nxny = 17'(r_nx) * 17'(r_ny);
    assign w_tz   = 26'(r_nxny) * 26'(r_az0);

    assign w_cz_last = (w_dims != 2'd3) || (r_kk == 2'd3);
    assign w_cy_last = (w_dims < 2'd2) || (r_jj == 2'd3);

    assign w_we = w_in_acc && (i_req_type == REQ_WRITE)
               && (32'(i_anchor_addr) < ANCHOR_DEPTH);
    assign w_re = (r_state == ST_FETCH) && (r_fa < DEPTH_A);

    assign w_cb_start = (r_state == ST_CUBIC) && r_cb_go;

    assign w_hi       = r_res > SMAX_V;
    assign w_lo_sat   = r_res < SMIN_V;
    assign w_out_free = !r_ovalid || i_out_ready;

    crgu_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({w_dval, FRAC_BITS'(0)}),
        .i_divisor  (w_dsor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    crgu_store #(.DEPTH(ANCHOR_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (IW'(i_anchor_addr)),
        .i_wdata (i_anchor_value),
        .i_re    (w_re),
        .i_raddr (IW'(r_fa)),
        .o_rdata (w_rdata)
    );

    crgu_cubic #(.FRAC_BITS(FRAC_BITS)) u_cubic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_cb_start),
        .i_p0     (r_ln[r_lvl][0]),
        .i_p1     (r_ln[r_lvl][1]),
        .i_p2     (r_ln[r_lvl][2]),
        .i_p3     (r_ln[r_lvl][3]),
        .i_frac   (r_frac[r_lvl]),
        .o_done   (w_cb_done),
        .o_result (w_cb_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_dims   <= 2'd3;
            r_w      <= SIZE_W'(256);
            r_h      <= SIZE_W'(1);
            r_d      <= SIZE_W'(1);
            r_sx     <= STEP_W'(4);
            r_sy     <= STEP_W'(4);
            r_sz     <= STEP_W'(4);
            r_ovalid <= 1'b0;
            r_cb_go  <= 1'b0;
            r_didx   <= '0;
            for (int l = 0; l < 3; l++) begin
                r_cnt[l] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_DIMENSIONS: r_dims <= i_cfg_data[1:0];
                    REG_OUT_WIDTH:  r_w    <= i_cfg_data;
                    REG_OUT_HEIGHT: r_h    <= i_cfg_data;
                    REG_OUT_DEPTH:  r_d    <= i_cfg_data;
                    REG_STEP_X:     r_sx   <= i_cfg_data[STEP_W-1:0];
                    REG_STEP_Y:     r_sy   <= i_cfg_data[STEP_W-1:0];
                    REG_STEP_Z:     r_sz   <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end

            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end

            r_cb_go <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && i_req_type == REQ_READ) begin
                        r_px   <= i_point_x;
                        r_py   <= i_point_y;
                        r_pz   <= i_point_z;
                        r_didx <= '0;
                        r_bad  <= w_coord_bad;
                        for (int l = 0; l < 3; l++) begin
                            r_cnt[l] <= '0;
                        end
                        r_state <= w_coord_bad ? ST_DONE : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_need) begin
                        r_state <= ST_DWAIT;
                    end else if (r_didx == 3'd4) begin
                        r_state <= ST_SET1;
                    end else begin
                        r_didx <= r_didx + 3'd1;
                    end
                end
                ST_DWAIT: begin
                    if (w_div_done) begin
                        case (r_didx)
                            3'd0: begin
                                r_ax0 <= w_q + SIZE_W'(1);
                                r_frac[2] <= w_quo[FRAC_BITS-1:0];
                            end
                            3'd1: begin
                                r_ay0 <= w_q + SIZE_W'(1);
                                r_frac[1] <= w_quo[FRAC_BITS-1:0];
                            end
                            3'd2: begin
                                r_az0 <= w_q + SIZE_W'(1);
                                r_frac[0] <= w_quo[FRAC_BITS-1:0];
                            end
                            3'd3: r_nx <= w_q + SIZE_W'(4);
                            default: r_ny <= w_q + SIZE_W'(4);
                        endcase
                        if (r_didx == 3'd4) begin
                            r_state <= ST_SET1;
                        end else begin
                            r_didx  <= r_didx + 3'd1;
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_SET1: begin
                    r_ty    <= (w_dims >= 2'd2) ? ADDR_W'(w_ty) : '0;
                    r_nxny  <= w_nxny;
                    r_state <= ST_SET2;
                end
                ST_SET2: begin
                    r_tz    <= (w_dims == 2'd3) ? ADDR_W'(w_tz) : '0;
                    r_state <= ST_SET3;
                end
                ST_SET3: begin
                    r_row_i <= ADDR_W'(r_ax0) + r_ty + r_tz;
                    r_row_j <= ADDR_W'(r_ax0) + r_ty + r_tz;
                    r_fa    <= ADDR_W'(r_ax0) + r_ty + r_tz;
                    r_ii    <= '0;
                    r_jj    <= '0;
                    r_kk    <= '0;
                    r_state <= ST_FETCH;
                end
                ST_FETCH: begin
                    if (r_fa >= DEPTH_A) begin
                        r_bad   <= 1'b1;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    // next neighbour, z fastest
                    if (!w_cz_last) begin
                        r_kk <= r_kk + 2'd1;
                        r_fa <= r_fa + ADDR_W'(r_nxny);
                    end else if (!w_cy_last) begin
                        r_kk    <= '0;
                        r_jj    <= r_jj + 2'd1;
                        r_row_j <= r_row_j + ADDR_W'(r_nx);
                        r_fa    <= r_row_j + ADDR_W'(r_nx);
                    end else begin
                        r_kk    <= '0;
                        r_jj    <= '0;
                        r_ii    <= r_ii + 2'd1;
                        r_row_i <= r_row_i + ADDR_W'(1);
                        r_row_j <= r_row_i + ADDR_W'(1);
                        r_fa    <= r_row_i + ADDR_W'(1);
                    end
                    for (int l = 0; l < 3; l++) begin
                        if (l == int'(w_lo)) begin
                            r_ln[l][0] <= r_ln[l][1];
                            r_ln[l][1] <= r_ln[l][2];
                            r_ln[l][2] <= r_ln[l][3];
                            r_ln[l][3] <= VAL_W'(w_rdata);
                        end
                    end
                    if (r_cnt[w_lo] == 2'd3) begin
                        r_cnt[w_lo] <= '0;
                        r_lvl       <= w_lo;
                        r_cb_go     <= 1'b1;
                        r_state     <= ST_CUBIC;
                    end else begin
                        r_cnt[w_lo] <= r_cnt[w_lo] + 2'd1;
                        r_state     <= ST_FETCH;
                    end
                end
                ST_CUBIC: begin
                    if (w_cb_done) begin
                        if (r_lvl == 2'd2) begin
                            r_res   <= w_cb_res;
                            r_state <= ST_DONE;
                        end else begin
                            for (int l = 0; l < 3; l++) begin
                                if (l == int'(r_lvl) + 1) begin
                                    r_ln[l][0] <= r_ln[l][1];
                                    r_ln[l][1] <= r_ln[l][2];
                                    r_ln[l][2] <= r_ln[l][3];
                                    r_ln[l][3] <= w_cb_res;
                                end
                            end
                            if (r_cnt[r_lvl + 2'd1] == 2'd3) begin
                                r_cnt[r_lvl + 2'd1] <= '0;
                                r_lvl   <= r_lvl + 2'd1;
                                r_cb_go <= 1'b1;
                            end else begin
                                r_cnt[r_lvl + 2'd1] <= r_cnt[r_lvl + 2'd1] + 2'd1;
                                r_state <= ST_FETCH;
                            end
                        end
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        if (r_bad) begin
                            r_oval <= '0;
                            r_osat <= 1'b0;
                            r_obad <= 1'b1;
                        end else begin
                            r_oval <= w_hi ? SMAX_V[SAMPLE_BITS-1:0]
                                    : w_lo_sat ? SMIN_V[SAMPLE_BITS-1:0]
                                    : r_res[SAMPLE_BITS-1:0];
                            r_osat <= w_hi || w_lo_sat;
                            r_obad <= 1'b0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_ovalid;
    assign o_sample_value = r_oval;
    assign o_saturated    = r_osat;
    assign o_bad_index    = r_obad;

    a_bad_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_index) |-> (o_sample_value == '0 && !o_saturated))
        else $error("bad-index beat carries data");

    a_fetch_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> ($past(r_fa) < DEPTH_A))
        else $error("anchor fetched beyond memory");

    a_out_from_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside completion");

    a_cubic_level : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CUBIC) |-> (r_lvl != 2'd3))
        else $error("spline level out of range");

endmodule
